### rtl/pptx_pkg.sv
// package: payload types and constants for the projective point transform
package pptx_pkg;

  localparam int unsigned CoefW = 32;
  localparam int unsigned OutW  = 40;
  localparam int unsigned MagW  = 64;
  localparam int unsigned SumW  = 66;
  localparam int unsigned AddrW = 6;
  localparam int unsigned DataW = 64;
  localparam int unsigned DivSteps = 40;

  // register indexes
  localparam logic [2:0] RegRow0Ab    = 3'd0;
  localparam logic [2:0] RegRow0cRow1a = 3'd1;
  localparam logic [2:0] RegRow1Bc    = 3'd2;
  localparam logic [2:0] RegRow2Ab    = 3'd3;
  localparam logic [2:0] RegRow2C     = 3'd4;

  localparam logic [63:0] CoefOne = 64'd16777216;
  localparam logic signed [OutW-1:0] QMax = {1'b0, {(OutW-1){1'b1}}};
  localparam logic signed [OutW-1:0] QMin = {1'b1, {(OutW-1){1'b0}}};

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } in_t;

  typedef struct packed {
    logic signed [39:0] mapped_x;
    logic signed [39:0] mapped_y;
    logic               bad_divide;
  } out_t;

  // one row result as sign and magnitude
  typedef struct packed {
    logic            neg;
    logic            zero;
    logic [MagW-1:0] mag;
  } row_t;

  typedef struct packed {
    logic signed [CoefW-1:0] h00, h01, h02, h10, h11, h12, h20, h21, h22;
  } coef_t;

  // per-coordinate control that rides beside the divider
  typedef struct packed {
    logic nneg;
    logic nzero;
    logic big;
  } side_t;

endpackage

### rtl/projective_point_transform_top.sv
// Pipeline from input beat to result beat: 2 product/sum stages,
// 1 range-check stage, 40 divider stages, 1 output stage.
// Throughput: one point per cycle unless stalled; the 40-stage restoring
// divider sets depth. A stalled result holds the whole pipeline in place.
// Reset (rst_n, synchronous) clears valid bits and loads the identity matrix.
// top level: homography point transform with APB coefficient registers
module projective_point_transform_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  pptx_pkg::in_t               in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output pptx_pkg::out_t              out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pptx_pkg::AddrW-1:0]  paddr,
  input  logic [pptx_pkg::DataW-1:0]  pwdata,
  output logic [pptx_pkg::DataW-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned N = pptx_pkg::DivSteps;

  logic [63:0] reg0_r, reg1_r, reg2_r, reg3_r;
  logic [31:0] reg4_r;
  logic        wr;
  logic [2:0]  idx;
  logic        en;
  pptx_pkg::coef_t coef;
  logic        rv;
  pptx_pkg::row_t u_row, v_row, w_row;
  logic        v3_r;
  logic [pptx_pkg::MagW-1:0] un_r, vn_r, wd_r;
  pptx_pkg::side_t sx_nxt, sy_nxt;
  pptx_pkg::side_t sx_r [N+1];
  pptx_pkg::side_t sy_r [N+1];
  logic        dneg_r [N+1];
  logic        dzero_r [N+1];
  logic [N:0]  vd_r;
  logic [N-1:0] qx, qy;
  logic signed [pptx_pkg::OutW-1:0] mx, my;
  logic        fx, fy;
  pptx_pkg::out_t out_r;
  logic        ov_r;

  // config port
  assign pready = 1'b1;
  assign idx = paddr[5:3];
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg0_r <= pptx_pkg::CoefOne;
      reg1_r <= '0;
      reg2_r <= pptx_pkg::CoefOne;
      reg3_r <= '0;
      reg4_r <= pptx_pkg::CoefOne[31:0];
    end else if (wr) begin
      case (idx)
        pptx_pkg::RegRow0Ab:     reg0_r <= pwdata;
        pptx_pkg::RegRow0cRow1a: reg1_r <= pwdata;
        pptx_pkg::RegRow1Bc:     reg2_r <= pwdata;
        pptx_pkg::RegRow2Ab:     reg3_r <= pwdata;
        pptx_pkg::RegRow2C:      reg4_r <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pptx_pkg::RegRow0Ab:     prdata = reg0_r;
      pptx_pkg::RegRow0cRow1a: prdata = reg1_r;
      pptx_pkg::RegRow1Bc:     prdata = reg2_r;
      pptx_pkg::RegRow2Ab:     prdata = reg3_r;
      pptx_pkg::RegRow2C:      prdata = {32'b0, reg4_r};
      default:                 prdata = '0;
    endcase
  end

  always_comb begin
    coef.h00 = reg0_r[31:0];
    coef.h01 = reg0_r[63:32];
    coef.h02 = reg1_r[31:0];
    coef.h10 = reg1_r[63:32];
    coef.h11 = reg2_r[31:0];
    coef.h12 = reg2_r[63:32];
    coef.h20 = reg3_r[31:0];
    coef.h21 = reg3_r[63:32];
    coef.h22 = reg4_r;
  end

  // pipeline advance
  assign en = !(ov_r && out_stall);
  assign in_stall = !en;

  pptx_rows u_rows (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_in  (in_valid),
    .pt        (in_data),
    .coef      (coef),
    .valid_out (rv),
    .u_row     (u_row),
    .v_row     (v_row),
    .w_row     (w_row)
  );

  // range check: quotient of 2^40 or more when num >= den * 2^16
  always_comb begin
    sx_nxt.nneg  = u_row.neg;
    sx_nxt.nzero = u_row.zero;
    sx_nxt.big   = {16'b0, u_row.mag} >= {w_row.mag, 16'b0};
    sy_nxt.nneg  = v_row.neg;
    sy_nxt.nzero = v_row.zero;
    sy_nxt.big   = {16'b0, v_row.mag} >= {w_row.mag, 16'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      un_r       <= u_row.mag;
      vn_r       <= v_row.mag;
      wd_r       <= w_row.mag;
      sx_r[0]    <= sx_nxt;
      sy_r[0]    <= sy_nxt;
      dneg_r[0]  <= w_row.neg;
      dzero_r[0] <= w_row.zero;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= rv;
    end
  end

  pptx_div u_div_x (.clk(clk), .en(en), .num(un_r), .den(wd_r), .quo(qx));
  pptx_div u_div_y (.clk(clk), .en(en), .num(vn_r), .den(wd_r), .quo(qy));

  // side-band control alongside the divider stages
  assign vd_r[0] = v3_r;
  for (genvar g = 0; g < N; g++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        sx_r[g+1]    <= sx_r[g];
        sy_r[g+1]    <= sy_r[g];
        dneg_r[g+1]  <= dneg_r[g];
        dzero_r[g+1] <= dzero_r[g];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[g+1] <= 1'b0;
      end else if (en) begin
        vd_r[g+1] <= vd_r[g];
      end
    end
  end

  // sign, saturation and zero-divisor handling
  function automatic logic [pptx_pkg::OutW:0] finish(input pptx_pkg::side_t s,
                                                     input logic dneg,
                                                     input logic dzero,
                                                     input logic [N-1:0] q);
    logic neg;
    logic signed [pptx_pkg::OutW-1:0] val;
    logic flag;
    neg  = s.nneg ^ dneg;
    flag = 1'b0;
    val  = '0;
    if (dzero) begin
      flag = 1'b1;
      val  = s.nzero ? '0 : (s.nneg ? pptx_pkg::QMin : pptx_pkg::QMax);
    end else if (s.big) begin
      flag = 1'b1;
      val  = neg ? pptx_pkg::QMin : pptx_pkg::QMax;
    end else if (neg && q != '0) begin
      if (q > {1'b1, {(N-1){1'b0}}}) begin
        flag = 1'b1;
        val  = pptx_pkg::QMin;
      end else begin
        val = -q;
      end
    end else begin
      if (q[N-1]) begin
        flag = 1'b1;
        val  = pptx_pkg::QMax;
      end else begin
        val = q;
      end
    end
    return {flag, val};
  endfunction

  assign {fx, mx} = finish(sx_r[N], dneg_r[N], dzero_r[N], qx);
  assign {fy, my} = finish(sy_r[N], dneg_r[N], dzero_r[N], qy);

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_r.mapped_x   <= mx;
      out_r.mapped_y   <= my;
      out_r.bad_divide <= fx | fy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= vd_r[N];
    end
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

  // checks
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall not tied to output backpressure");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(vd_r) && $stable(v3_r))
    else $error("pipeline valid bits moved during a stall");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

endmodule

### rtl/pptx_rows.sv
// module: matrix-vector product stages, giving u, v, w as sign and magnitude
module pptx_rows (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            valid_in,
  input  pptx_pkg::in_t   pt,
  input  pptx_pkg::coef_t coef,
  output logic            valid_out,
  output pptx_pkg::row_t  u_row,
  output pptx_pkg::row_t  v_row,
  output pptx_pkg::row_t  w_row
);

  logic signed [63:0] p_nxt [6];
  logic signed [63:0] p_r   [6];
  logic signed [47:0] c_r   [3];
  logic               v1_r, v2_r;
  pptx_pkg::row_t     u_r, v_r, w_r;

  // stage one: six products
  always_comb begin
    p_nxt[0] = coef.h00 * pt.point_x;
    p_nxt[1] = coef.h01 * pt.point_y;
    p_nxt[2] = coef.h10 * pt.point_x;
    p_nxt[3] = coef.h11 * pt.point_y;
    p_nxt[4] = coef.h20 * pt.point_x;
    p_nxt[5] = coef.h21 * pt.point_y;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) p_r[i] <= p_nxt[i];
      c_r[0] <= {coef.h02, 16'b0};
      c_r[1] <= {coef.h12, 16'b0};
      c_r[2] <= {coef.h22, 16'b0};
    end
  end

  // stage two: row sums folded to sign and magnitude
  function automatic pptx_pkg::row_t fold(input logic signed [63:0] a,
                                          input logic signed [63:0] b,
                                          input logic signed [47:0] c);
    logic signed [pptx_pkg::SumW-1:0] s;
    logic signed [pptx_pkg::SumW-1:0] m;
    pptx_pkg::row_t r;
    s = {{2{a[63]}}, a} + {{2{b[63]}}, b} + {{18{c[47]}}, c};
    m = s[pptx_pkg::SumW-1] ? -s : s;
    r.neg  = s[pptx_pkg::SumW-1];
    r.zero = (s == '0);
    r.mag  = m[pptx_pkg::MagW-1:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      u_r <= fold(p_r[0], p_r[1], c_r[0]);
      v_r <= fold(p_r[2], p_r[3], c_r[1]);
      w_r <= fold(p_r[4], p_r[5], c_r[2]);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_in;
      v2_r <= v1_r;
    end
  end

  assign valid_out = v2_r;
  assign u_row = u_r;
  assign v_row = v_r;
  assign w_row = w_r;

endmodule

### rtl/pptx_div.sv
// module: pipelined restoring divider, one quotient bit per stage
module pptx_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [pptx_pkg::MagW-1:0]    num,
  input  logic [pptx_pkg::MagW-1:0]    den,
  output logic [pptx_pkg::DivSteps-1:0] quo
);

  localparam int unsigned N = pptx_pkg::DivSteps;
  localparam int unsigned W = pptx_pkg::MagW;

  logic [W-1:0] rem_r [N+1];
  logic [W-1:0] den_r [N+1];
  logic [N-1:0] low_r [N+1];
  logic [N-1:0] q_r   [N+1];

  // entry: high part of the scaled numerator seeds the remainder
  always_comb begin
    rem_r[0] = {16'b0, num[W-1:16]};
    den_r[0] = den;
    low_r[0] = {num[15:0], 24'b0};
    q_r[0]   = '0;
  end

  for (genvar g = 0; g < N; g++) begin : g_step
    logic [W:0] trial;
    logic       take;
    assign trial = {rem_r[g], low_r[g][N-1]};
    assign take  = (trial >= {1'b0, den_r[g]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g+1] <= take ? W'(trial - {1'b0, den_r[g]}) : trial[W-1:0];
        den_r[g+1] <= den_r[g];
        low_r[g+1] <= {low_r[g][N-2:0], 1'b0};
        q_r[g+1]   <= {q_r[g][N-2:0], take};
      end
    end
  end

  assign quo = q_r[N];

endmodule
